### hw/rtl/contact_pair_aging_table_core_assert.svh
// Assertion macros for the contact pair aging table.
`ifndef CONTACT_PAIR_AGING_TABLE_CORE_ASSERT_SVH
`define CONTACT_PAIR_AGING_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CPAT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CPAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/cpat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpat_pkg;

   localparam int DEF_TABLE_DEPTH = 32;
   localparam int DEF_ID_BITS     = 16;
   localparam int SHAPE_BITS      = 16;
   localparam int LIMIT_BITS      = 8;
   localparam int AGE_BITS        = 9;
   localparam int REMOVED_BITS    = 7;
   localparam int GRP_SIZE        = 8;
   localparam int GCNT_W          = $clog2(GRP_SIZE + 1);

   localparam logic [AGE_BITS-1:0]     AGE_MAX       = '1;
   localparam logic [LIMIT_BITS-1:0]   EXPIRE_RESET  = 8'd10;
   localparam logic [REMOVED_BITS-1:0] REMOVED_SAT   = '1;

   localparam logic REQ_REPORT = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   typedef enum logic [2:0] {
      ST_IGNORED  = 3'd0,
      ST_REFRESH  = 3'd1,
      ST_INSERTED = 3'd2,
      ST_FULL     = 3'd3,
      ST_TICK     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SUM1,
      S_SUM2
   } state_type;

   // per-table command for the cell row
   typedef struct packed {
      logic report_en;
      logic tick_en;
   } chain_ctrl_type;

   typedef struct packed {
      logic hit;
      logic has_free;
   } chain_stat_type;

endpackage

`default_nettype wire

### hw/rtl/cpat_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module cpat_cell #(
   parameter int ID_BITS = cpat_pkg::DEF_ID_BITS
) (
   input  wire                              clock,
   input  wire                              reset,
   input  cpat_pkg::chain_ctrl_type         ctrl,
   input  wire                              insert_en,
   input  wire  [ID_BITS-1:0]               id_a,
   input  wire  [ID_BITS-1:0]               id_b,
   input  wire  [cpat_pkg::LIMIT_BITS-1:0]  limit,
   input  wire                              free_before,
   output logic                             free_through,
   output logic                             match,
   output logic                             expire
);

   logic                           used_ff, used_in;
   logic [ID_BITS-1:0]             ida_ff, ida_in;
   logic [ID_BITS-1:0]             idb_ff, idb_in;
   logic [cpat_pkg::AGE_BITS-1:0]  age_ff, age_in;
   logic                           expire_ff, expire_in;
   logic [cpat_pkg::AGE_BITS-1:0]  aged;
   logic                           too_old;

   assign match        = used_ff && (ida_ff == id_a) && (idb_ff == id_b);
   assign free_through = free_before || !used_ff;
   assign expire       = expire_ff;

   assign aged    = (age_ff == cpat_pkg::AGE_MAX) ? age_ff : age_ff + 1'b1;
   assign too_old = aged > cpat_pkg::AGE_BITS'(limit);

   always_comb begin
      used_in   = used_ff;
      ida_in    = ida_ff;
      idb_in    = idb_ff;
      age_in    = age_ff;
      expire_in = 1'b0;
      if (ctrl.report_en && match) begin
         age_in = '0;
      end
      // only the first free cell of the row takes a new pair
      if (insert_en && !free_before && !used_ff) begin
         used_in = 1'b1;
         ida_in  = id_a;
         idb_in  = id_b;
         age_in  = '0;
      end
      if (ctrl.tick_en && used_ff) begin
         age_in = aged;
         if (too_old) begin
            used_in   = 1'b0;
            expire_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      ida_ff    <= ida_in;
      idb_ff    <= idb_in;
      age_ff    <= age_in;
      expire_ff <= expire_in;
   end

endmodule

`default_nettype wire

### hw/rtl/cpat_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module cpat_chain #(
   parameter  int TABLE_DEPTH = cpat_pkg::DEF_TABLE_DEPTH,
   parameter  int ID_BITS     = cpat_pkg::DEF_ID_BITS,
   localparam int GROUPS      = (TABLE_DEPTH + cpat_pkg::GRP_SIZE - 1) / cpat_pkg::GRP_SIZE
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  cpat_pkg::chain_ctrl_type                  ctrl,
   input  wire  [ID_BITS-1:0]                        id_a,
   input  wire  [ID_BITS-1:0]                        id_b,
   input  wire  [cpat_pkg::LIMIT_BITS-1:0]           limit,
   output cpat_pkg::chain_stat_type                  stat,
   output logic [GROUPS-1:0][cpat_pkg::GCNT_W-1:0]   grp_cnt
);

   localparam int PAD = GROUPS * cpat_pkg::GRP_SIZE;

   logic [TABLE_DEPTH:0]   free_link;
   logic [TABLE_DEPTH-1:0] match_vec;
   logic [TABLE_DEPTH-1:0] expire_vec;
   logic [PAD-1:0]         expire_pad;
   logic                   insert_en;
   logic [GROUPS-1:0][cpat_pkg::GCNT_W-1:0] grp_cnt_ff, grp_cnt_in;

   assign free_link[0]  = 1'b0;
   assign stat.hit      = |match_vec;
   assign stat.has_free = free_link[TABLE_DEPTH];
   assign insert_en     = ctrl.report_en && !stat.hit;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      cpat_cell #(
         .ID_BITS(ID_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .insert_en   (insert_en),
         .id_a        (id_a),
         .id_b        (id_b),
         .limit       (limit),
         .free_before (free_link[i]),
         .free_through(free_link[i+1]),
         .match       (match_vec[i]),
         .expire      (expire_vec[i])
      );
   end

   // first level of the expire count tree: one small popcount per group
   assign expire_pad = PAD'(expire_vec);

   always_comb begin
      grp_cnt_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         for (int j = 0; j < cpat_pkg::GRP_SIZE; j++) begin
            grp_cnt_in[g] = grp_cnt_in[g]
                          + cpat_pkg::GCNT_W'(expire_pad[g*cpat_pkg::GRP_SIZE + j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_cnt_ff <= grp_cnt_in;
   end

   assign grp_cnt = grp_cnt_ff;

endmodule

`default_nettype wire

### hw/rtl/contact_pair_aging_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Two tables (contact, trigger) of shape-id pairs with aging. Raise start for one
// cycle with busy low to hand in a transaction. A pair report passes through S_EXEC
// and strobes its result from the registered rsp_ ports; a frame tick passes through
// S_EXEC, S_SUM1 and S_SUM2 before its result is strobed, since the expired entries
// are counted through a two-level adder tree after the cell row has aged. busy covers
// every cycle in between. Every transaction gives exactly one
// result, shown on the rsp_ ports for a single cycle with rsp_valid high; there is
// no back-pressure, so the receiver must take it in that cycle. A new transaction
// may be accepted in the same cycle the previous result is strobed. Write
// expire_frames only while busy is low and no result is pending.

module contact_pair_aging_table_core #(
   parameter int TABLE_DEPTH = cpat_pkg::DEF_TABLE_DEPTH,
   parameter int ID_BITS     = cpat_pkg::DEF_ID_BITS
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire                                 req_type,
   input  wire  [cpat_pkg::SHAPE_BITS-1:0]     req_shape_a,
   input  wire  [cpat_pkg::SHAPE_BITS-1:0]     req_shape_b,
   input  wire                                 req_is_trigger,
   input  wire                                 req_sim_pair,
   input  wire                                 req_blocking,
   input  wire                                 req_trigger_ok,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_table_sel,
   output logic [cpat_pkg::SHAPE_BITS-1:0]     rsp_report_shape_a,
   output logic [cpat_pkg::SHAPE_BITS-1:0]     rsp_report_shape_b,
   output logic [cpat_pkg::REMOVED_BITS-1:0]   rsp_removed_count,
   input  wire                                 csr_wr_en,
   input  wire  [cpat_pkg::LIMIT_BITS-1:0]     csr_wr_data
);

   localparam int GROUPS = (TABLE_DEPTH + cpat_pkg::GRP_SIZE - 1) / cpat_pkg::GRP_SIZE;
   localparam int SUM_RAW = $clog2(2 * TABLE_DEPTH + 1);
   localparam int SUM_W   = (SUM_RAW > cpat_pkg::REMOVED_BITS + 1)
                          ? SUM_RAW : cpat_pkg::REMOVED_BITS + 1;

   cpat_pkg::state_type state_ff, state_in;

   logic                            accept;
   logic                            exec_report, exec_tick, sum_done;
   logic [cpat_pkg::LIMIT_BITS-1:0] expire_ff;

   logic                  type_ff;
   logic [ID_BITS-1:0]    a_ff, b_ff;
   logic                  trig_ff;
   logic                  qual_ff, qual_in;

   cpat_pkg::chain_ctrl_type cont_ctrl, trig_ctrl;
   cpat_pkg::chain_stat_type cont_stat, trig_stat, sel_stat;
   logic [GROUPS-1:0][cpat_pkg::GCNT_W-1:0] cont_grp, trig_grp;

   logic [SUM_W-1:0]                   total;
   logic [cpat_pkg::REMOVED_BITS-1:0]  removed;
   cpat_pkg::status_type               report_status;

   logic                                rsp_valid_ff, rsp_valid_in;
   cpat_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic                                rsp_sel_ff, rsp_sel_in;
   logic [cpat_pkg::SHAPE_BITS-1:0]     rsp_a_ff, rsp_a_in, rsp_b_ff, rsp_b_in;
   logic [cpat_pkg::REMOVED_BITS-1:0]   rsp_cnt_ff, rsp_cnt_in;

   assign accept  = start && !busy;
   assign qual_in = req_blocking && (req_is_trigger || req_sim_pair)
                 && (!req_is_trigger || req_trigger_ok);

   // ---------------- control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cpat_pkg::S_IDLE: begin
            if (accept) begin
               state_in = cpat_pkg::S_EXEC;
            end
         end
         cpat_pkg::S_EXEC: begin
            state_in = (type_ff == cpat_pkg::REQ_TICK) ? cpat_pkg::S_SUM1 : cpat_pkg::S_IDLE;
         end
         cpat_pkg::S_SUM1: state_in = cpat_pkg::S_SUM2;
         cpat_pkg::S_SUM2: state_in = cpat_pkg::S_IDLE;
         default:          state_in = cpat_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      busy        = 1'b1;
      exec_report = 1'b0;
      exec_tick   = 1'b0;
      sum_done    = 1'b0;
      unique case (state_ff)
         cpat_pkg::S_IDLE: busy = 1'b0;
         cpat_pkg::S_EXEC: begin
            exec_report = (type_ff == cpat_pkg::REQ_REPORT);
            exec_tick   = (type_ff == cpat_pkg::REQ_TICK);
         end
         cpat_pkg::S_SUM1: ;
         cpat_pkg::S_SUM2: sum_done = 1'b1;
         default:          busy = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpat_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         expire_ff    <= cpat_pkg::EXPIRE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            expire_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         a_ff    <= ID_BITS'({16'd0, req_shape_a});
         b_ff    <= ID_BITS'({16'd0, req_shape_b});
         trig_ff <= req_is_trigger;
         qual_ff <= qual_in;
      end
   end

   // ---------------- cell rows
   assign cont_ctrl.report_en = exec_report && qual_ff && !trig_ff;
   assign cont_ctrl.tick_en   = exec_tick;
   assign trig_ctrl.report_en = exec_report && qual_ff && trig_ff;
   assign trig_ctrl.tick_en   = exec_tick;

   cpat_chain #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .ID_BITS    (ID_BITS)
   ) u_cont (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (cont_ctrl),
      .id_a   (a_ff),
      .id_b   (b_ff),
      .limit  (expire_ff),
      .stat   (cont_stat),
      .grp_cnt(cont_grp)
   );

   cpat_chain #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .ID_BITS    (ID_BITS)
   ) u_trig (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (trig_ctrl),
      .id_a   (a_ff),
      .id_b   (b_ff),
      .limit  (expire_ff),
      .stat   (trig_stat),
      .grp_cnt(trig_grp)
   );

   // ---------------- result
   assign sel_stat = trig_ff ? trig_stat : cont_stat;

   always_comb begin
      if (!qual_ff) begin
         report_status = cpat_pkg::ST_IGNORED;
      end else if (sel_stat.hit) begin
         report_status = cpat_pkg::ST_REFRESH;
      end else if (sel_stat.has_free) begin
         report_status = cpat_pkg::ST_INSERTED;
      end else begin
         report_status = cpat_pkg::ST_FULL;
      end
   end

   // second level of the expire count tree
   always_comb begin
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total = total + SUM_W'(cont_grp[g]) + SUM_W'(trig_grp[g]);
      end
      removed = (total > SUM_W'(cpat_pkg::REMOVED_SAT))
              ? cpat_pkg::REMOVED_SAT : cpat_pkg::REMOVED_BITS'(total);
   end

   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_status_in = cpat_pkg::ST_IGNORED;
      rsp_sel_in    = 1'b0;
      rsp_a_in      = '0;
      rsp_b_in      = '0;
      rsp_cnt_in    = '0;
      if (exec_report) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = report_status;
         if (qual_ff) begin
            rsp_sel_in = trig_ff;
            rsp_a_in   = cpat_pkg::SHAPE_BITS'(32'(a_ff));
            rsp_b_in   = cpat_pkg::SHAPE_BITS'(32'(b_ff));
         end
      end else if (sum_done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cpat_pkg::ST_TICK;
         rsp_cnt_in    = removed;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_sel_ff    <= rsp_sel_in;
      rsp_a_ff      <= rsp_a_in;
      rsp_b_ff      <= rsp_b_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_table_sel      = rsp_sel_ff;
   assign rsp_report_shape_a = rsp_a_ff;
   assign rsp_report_shape_b = rsp_b_ff;
   assign rsp_removed_count  = rsp_cnt_ff;

   // ---------------- checks
`include "contact_pair_aging_table_core_assert.svh"

   `CPAT_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "accepted transaction did not raise busy")
   `CPAT_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy, "result strobed while still busy")
   `CPAT_ASSERT_NOW(a_cnt_tick_only, clock, reset, rsp_valid && (rsp_status != cpat_pkg::ST_TICK), rsp_removed_count == '0, "removed count on a report transaction")
   `CPAT_ASSERT_NEXT(a_report_strobe, clock, reset, exec_report, rsp_valid && (rsp_status != cpat_pkg::ST_TICK), "report transaction gave no report result")

endmodule

`default_nettype wire
